@@ hw/rtl/wavefold_lowpass_feedback_delay_unit_macros.svh @@
// Assertion macros used by the checker file.
`ifndef WAVEFOLD_LOWPASS_FEEDBACK_DELAY_UNIT_MACROS_SVH
`define WAVEFOLD_LOWPASS_FEEDBACK_DELAY_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define WLFD_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wavefold unit check failed");

// Consequent checked in the cycle after the antecedent.
`define WLFD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wavefold unit check failed");

`endif

@@ hw/rtl/wlfd_pkg.sv @@
package wlfd_pkg;

	localparam int DELAY_DEPTH_DEF = 65536;
	localparam int COS_ENTRIES_DEF = 1024;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] SERIES_DIV [1:8] = '{64'd2, 64'd12, 64'd30, 64'd56,
		64'd90, 64'd132, 64'd182, 64'd240};

	localparam logic [23:0] FOLD_GAIN_RST = 24'd32768;
	localparam logic [23:0] FOLD_OFFSET_RST = 24'd0;
	localparam logic [23:0] LP_COEFF_RST = 24'd4843170;
	localparam logic [23:0] DELAY_LEN_RST = 24'd12288000;
	localparam logic [15:0] FB_GAIN_RST = 16'd0;
	localparam logic [16:0] WET_MIX_RST = 17'd32768;
	localparam logic [16:0] WET_FULL = 17'd65536;

	localparam logic [23:0] PEAK_RESET = 24'd209715;
	localparam logic [23:0] PEAK_TWO = 24'd4194304;
	localparam logic [23:0] PEAK_HALF = 24'd1048576;
	localparam logic signed [31:0] RISE_Q24 = 32'sd5033165;
	localparam logic signed [31:0] DECAY_Q24 = 32'sd16760439;
	localparam logic signed [31:0] POLY_K0 = 32'sd26869366;
	localparam logic signed [31:0] POLY_K1 = -32'sd26939595;
	localparam logic signed [31:0] POLY_K2 = 32'sd14904709;
	localparam logic signed [31:0] POLY_K3 = 32'sd3028019;
	localparam logic signed [31:0] UNIT_Q22 = 32'sd4194304;

	// Reciprocals scaled by 2^32; exact floor quotients for 24-bit magnitudes.
	localparam logic signed [31:0] RECIP_9 = 32'sd477218589;
	localparam logic signed [31:0] RECIP_25 = 32'sd171798692;
	localparam logic signed [31:0] RECIP_49 = 32'sd87652394;

	typedef enum logic [2:0] {
		REG_FOLD_GAIN,
		REG_FOLD_OFFSET,
		REG_LOWPASS_COEFF,
		REG_DELAY_LENGTH,
		REG_FEEDBACK_GAIN,
		REG_WET_MIX
	} reg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_GAIN,
		ST_PHASE,
		ST_COS_ADDR,
		ST_COS_INTERP,
		ST_COS_DIV,
		ST_COS_ACC,
		ST_AP,
		ST_AP_SUM,
		ST_RD0,
		ST_RD1,
		ST_TAP,
		ST_MIX0,
		ST_MIX1,
		ST_FEED,
		ST_PEAK,
		ST_POLY2,
		ST_POLY1,
		ST_POLY0,
		ST_SCALE,
		ST_WRITE
	} state_t;

	function automatic logic signed [23:0] sat24(logic signed [63:0] v);
		if (v > 64'sd8388607) begin
			return 24'sd8388607;
		end else if (v < -64'sd8388608) begin
			return -24'sd8388608;
		end
		return v[23:0];
	endfunction

	// Taylor series of the cosine in Q2.30, rounded to Q1.23.
	function automatic logic [23:0] cos_series(logic [63:0] a);
		logic [63:0] a2;
		logic [63:0] term;
		logic signed [63:0] sum;
		a2 = (a * a) >> 30;
		term = 64'd1 << 30;
		sum = signed'(term);
		for (int n = 1; n <= 8; n++) begin
			term = ((term * a2) >> 30) / SERIES_DIV[n];
			if ((n & 1) == 1) begin
				sum = sum - signed'(term);
			end else begin
				sum = sum + signed'(term);
			end
		end
		if (sum > 64'sd0) begin
			return 24'((sum + 64'sd64) >>> 7);
		end
		return 24'd0;
	endfunction

endpackage

@@ hw/rtl/wlfd_ram.sv @@
module wlfd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

endmodule

@@ hw/rtl/wlfd_cos_rom.sv @@
module wlfd_cos_rom import wlfd_pkg::*; #(
	parameter int ENTRIES = COS_ENTRIES_DEF,
	localparam int AW = $clog2(ENTRIES + 1)
) (
	input  logic          clk,
	input  logic [AW-1:0] addr0,
	input  logic [AW-1:0] addr1,
	output logic [23:0]   data0_q,
	output logic [23:0]   data1_q
);

	logic [23:0] rom [ENTRIES + 1];

	for (genvar gi = 0; gi <= ENTRIES; gi++) begin : g_rom
		localparam logic [63:0] PHASE = (HALF_PI_Q30 * 64'(gi)) / 64'(ENTRIES);
		assign rom[gi] = cos_series(PHASE);
	end

	always_ff @(posedge clk) begin
		data0_q <= rom[addr0];
		data1_q <= rom[addr1];
	end

endmodule

@@ hw/rtl/wlfd_mul.sv @@
module wlfd_mul (
	input  logic               clk,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic signed [63:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

@@ hw/rtl/wavefold_lowpass_feedback_delay_unit.sv @@
// One sample at a time: in_ready is high only when idle, so a new input is taken only
// after the last is written; a sample waits at the mix step while the previous result
// is still held, and the polynomial gain steps run only when the updated peak level is
// above 0.5. All products come from the single shared 32x32 multiplier.
// Reset: arst_n resets the settings and control state at once; the delay line reads as
// zero until written, tracked by a fill count, so no clearing pass is needed.
module wavefold_lowpass_feedback_delay_unit import wlfd_pkg::*; #(
	parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
	parameter int COS_TABLE_ENTRIES = COS_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [23:0] sample_in,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [23:0] sample_out
);

	localparam int AW = $clog2(DELAY_DEPTH);
	localparam int CAW = $clog2(COS_TABLE_ENTRIES + 1);
	localparam logic [31:0] DLY_MAX = 32'((DELAY_DEPTH - 1) * 256);
	localparam logic [31:0] DLY_MIN = 32'd256;

	logic [23:0] fold_gain_q;
	logic [23:0] fold_offset_q;
	logic signed [23:0] lp_coeff_q;
	logic [23:0] delay_len_q;
	logic [15:0] fb_gain_q;
	logic [16:0] wet_mix_q;

	state_t state_q, state_d;
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] p_q;

	logic signed [23:0] x_q;
	logic [17:0] u_q;
	logic [1:0] h_q;
	logic neg_q;
	logic [15:0] fr_q;
	logic [23:0] v0_q;
	logic csgn_q;
	logic signed [26:0] sum_q;
	logic signed [23:0] fold_q;
	logic signed [23:0] prev_in_q, prev_ap_q;
	logic signed [23:0] lp_q;
	logic valid0_q, valid1_q;
	logic signed [23:0] t0_q;
	logic signed [24:0] tap_q;
	logic signed [63:0] acc_q;
	logic out_valid_q;
	logic signed [23:0] sample_out_q;
	logic signed [31:0] feed_q;
	logic rise_q;
	logic [23:0] peak_q;
	logic [AW-1:0] wp_q;
	logic [AW:0] fill_q;

	logic [23:0] rom0, rom1;
	logic [CAW-1:0] rom_addr0, rom_addr1;
	logic [23:0] ram_rdata;
	logic [AW-1:0] ram_raddr;
	logic ram_we;
	logic [23:0] ram_wdata;

	logic cfg_wr;
	logic [31:0] dly_raw, dly_cl;
	logic [AW-1:0] dly_int;
	logic [7:0] dly_frac;
	logic [AW:0] rp_sum, rp1_sum;
	logic [AW-1:0] rp, rp1;
	logic [16:0] wet_m;
	logic [17:0] ph;
	logic [16:0] qr;
	logic [31:0] pos;
	logic [CAW-1:0] cidx;
	logic signed [25:0] cos_q, cos_v, cos_abs;
	logic signed [31:0] recip;
	logic signed [26:0] dterm;
	logic signed [25:0] fold_w;
	logic signed [63:0] ap_full;
	logic signed [23:0] ap_sat;
	logic signed [24:0] lp_sum;
	logic signed [23:0] t1_v;
	logic signed [24:0] tap_v;
	logic signed [23:0] mix_o;
	logic out_free;
	logic signed [31:0] feed_v, feed_mag;
	logic [30:0] rect_w;
	logic [23:0] rect;
	logic [23:0] peak_new;
	logic signed [31:0] poly_g;
	logic signed [31:0] feed_cl;

	function automatic logic is_written(logic [AW-1:0] p, logic [AW:0] cnt);
		logic [AW:0] span;
		span = (p == '0) ? '0 : (AW + 1)'(DELAY_DEPTH) - {1'b0, p};
		return span < cnt;
	endfunction

	wlfd_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (p_q)
	);

	wlfd_cos_rom #(
		.ENTRIES (COS_TABLE_ENTRIES)
	) u_cos_rom (
		.clk     (clk),
		.addr0   (rom_addr0),
		.addr1   (rom_addr1),
		.data0_q (rom0),
		.data1_q (rom1)
	);

	wlfd_ram #(
		.WIDTH (24),
		.DEPTH (DELAY_DEPTH)
	) u_delay_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (wp_q),
		.wdata   (ram_wdata),
		.raddr   (ram_raddr),
		.rdata_q (ram_rdata)
	);

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign out_valid = out_valid_q;
	assign sample_out = sample_out_q;

	always_comb begin
		case (reg_idx_t'(paddr[4:2]))
			REG_FOLD_GAIN:     prdata = {8'd0, fold_gain_q};
			REG_FOLD_OFFSET:   prdata = {8'd0, fold_offset_q};
			REG_LOWPASS_COEFF: prdata = {8'd0, lp_coeff_q};
			REG_DELAY_LENGTH:  prdata = {8'd0, delay_len_q};
			REG_FEEDBACK_GAIN: prdata = {16'd0, fb_gain_q};
			REG_WET_MIX:       prdata = {15'd0, wet_mix_q};
			default:           prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_gain_q <= FOLD_GAIN_RST;
			fold_offset_q <= FOLD_OFFSET_RST;
			lp_coeff_q <= LP_COEFF_RST;
			delay_len_q <= DELAY_LEN_RST;
			fb_gain_q <= FB_GAIN_RST;
			wet_mix_q <= WET_MIX_RST;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[4:2]))
				REG_FOLD_GAIN:     fold_gain_q <= pwdata[23:0];
				REG_FOLD_OFFSET:   fold_offset_q <= pwdata[23:0];
				REG_LOWPASS_COEFF: lp_coeff_q <= pwdata[23:0];
				REG_DELAY_LENGTH:  delay_len_q <= pwdata[23:0];
				REG_FEEDBACK_GAIN: fb_gain_q <= pwdata[15:0];
				REG_WET_MIX:       wet_mix_q <= pwdata[16:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		dly_raw = {8'd0, delay_len_q};
		if (dly_raw < DLY_MIN) begin
			dly_cl = DLY_MIN;
		end else if (dly_raw > DLY_MAX) begin
			dly_cl = DLY_MAX;
		end else begin
			dly_cl = dly_raw;
		end
		dly_int = dly_cl[AW+7:8];
		dly_frac = dly_cl[7:0];
		rp_sum = {1'b0, wp_q} + {1'b0, dly_int};
		if (rp_sum >= (AW + 1)'(DELAY_DEPTH)) begin
			rp_sum = rp_sum - (AW + 1)'(DELAY_DEPTH);
		end
		rp = rp_sum[AW-1:0];
		rp1_sum = {1'b0, rp} + (AW + 1)'(1);
		if (rp1_sum >= (AW + 1)'(DELAY_DEPTH)) begin
			rp1_sum = rp1_sum - (AW + 1)'(DELAY_DEPTH);
		end
		rp1 = rp1_sum[AW-1:0];
		wet_m = (wet_mix_q > WET_FULL) ? WET_FULL : wet_mix_q;

		case (h_q)
			2'd0:    ph = u_q;
			2'd1:    ph = (u_q << 1) + u_q;
			2'd2:    ph = (u_q << 2) + u_q;
			default: ph = (u_q << 3) - u_q;
		endcase
		qr = ph[16] ? 17'd65536 - {1'b0, ph[15:0]} : {1'b0, ph[15:0]};
		pos = 32'(qr) * 32'(COS_TABLE_ENTRIES);
		cidx = pos[CAW+15:16];
		rom_addr0 = cidx;
		rom_addr1 = (cidx == CAW'(COS_TABLE_ENTRIES)) ? cidx : cidx + CAW'(1);

		cos_q = $signed({2'b00, v0_q}) + 26'(p_q >>> 16);
		cos_v = neg_q ? -cos_q : cos_q;
		cos_abs = cos_v[25] ? -cos_v : cos_v;
		case (h_q)
			2'd1:    recip = RECIP_9;
			2'd2:    recip = RECIP_25;
			default: recip = RECIP_49;
		endcase
		dterm = csgn_q ? -$signed({2'b00, p_q[56:32]}) : $signed({2'b00, p_q[56:32]});

		fold_w = 26'(sum_q >>> 1);
		ap_full = (p_q >>> 23) + 64'(prev_in_q);
		ap_sat = sat24(ap_full);
		lp_sum = 25'(fold_q) + 25'(ap_sat);

		t1_v = valid1_q ? $signed(ram_rdata) : 24'sd0;
		tap_v = 25'(t0_q) + 25'(p_q >>> 8);
		mix_o = sat24((acc_q + p_q) >>> 16);
		out_free = !out_valid_q || out_ready;

		feed_v = 32'(lp_q) + 32'(p_q >>> 15);
		feed_mag = feed_v[31] ? -feed_v : feed_v;
		rect_w = feed_mag[31:1];
		rect = (rect_w > 31'h00FFFFFF) ? 24'hFFFFFF : rect_w[23:0];
		peak_new = rise_q ? peak_q + p_q[47:24] : p_q[47:24];

		case (state_q)
			ST_POLY2: poly_g = POLY_K2 - 32'(p_q >>> 21);
			ST_POLY1: poly_g = POLY_K1 + 32'(p_q >>> 21);
			default:  poly_g = POLY_K0 + 32'(p_q >>> 21);
		endcase

		if (feed_q > UNIT_Q22) begin
			feed_cl = UNIT_Q22;
		end else if (feed_q < -UNIT_Q22) begin
			feed_cl = -UNIT_Q22;
		end else begin
			feed_cl = feed_q;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_GAIN;
				end
			end
			ST_GAIN:       state_d = ST_PHASE;
			ST_PHASE:      state_d = ST_COS_ADDR;
			ST_COS_ADDR:   state_d = ST_COS_INTERP;
			ST_COS_INTERP: state_d = ST_COS_DIV;
			ST_COS_DIV:    state_d = (h_q == 2'd0) ? ST_COS_ADDR : ST_COS_ACC;
			ST_COS_ACC:    state_d = (h_q == 2'd3) ? ST_AP : ST_COS_ADDR;
			ST_AP:         state_d = ST_AP_SUM;
			ST_AP_SUM:     state_d = ST_RD0;
			ST_RD0:        state_d = ST_RD1;
			ST_RD1:        state_d = ST_TAP;
			ST_TAP:        state_d = ST_MIX0;
			ST_MIX0:       state_d = ST_MIX1;
			ST_MIX1: begin
				if (out_free) begin
					state_d = ST_FEED;
				end
			end
			ST_FEED:       state_d = ST_PEAK;
			ST_PEAK:       state_d = (peak_new > PEAK_HALF) ? ST_POLY2 : ST_WRITE;
			ST_POLY2:      state_d = ST_POLY1;
			ST_POLY1:      state_d = ST_POLY0;
			ST_POLY0:      state_d = ST_SCALE;
			ST_SCALE:      state_d = ST_WRITE;
			ST_WRITE:      state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		mul_a = 32'sd0;
		mul_b = 32'sd0;
		ram_raddr = rp;
		ram_we = 1'b0;
		ram_wdata = feed_cl[23:0];
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_GAIN: begin
				mul_a = $signed({8'd0, fold_gain_q});
				mul_b = 32'(x_q);
			end
			ST_COS_INTERP: begin
				mul_a = $signed({8'd0, rom1}) - $signed({8'd0, rom0});
				mul_b = $signed({16'd0, fr_q});
			end
			ST_COS_DIV: begin
				mul_a = 32'(cos_abs);
				mul_b = recip;
			end
			ST_AP: begin
				mul_a = 32'(lp_coeff_q);
				mul_b = 32'(fold_w) - 32'(prev_ap_q);
			end
			ST_AP_SUM: ram_raddr = rp;
			ST_RD0:    ram_raddr = rp1;
			ST_RD1: begin
				mul_a = 32'(t1_v) - 32'(t0_q);
				mul_b = $signed({24'd0, dly_frac});
			end
			ST_TAP: begin
				mul_a = 32'(lp_q);
				mul_b = $signed({15'd0, WET_FULL - wet_m});
			end
			ST_MIX0: begin
				mul_a = 32'(tap_q);
				mul_b = $signed({15'd0, wet_m});
			end
			ST_MIX1: begin
				if (out_free) begin
					mul_a = $signed({16'd0, fb_gain_q});
					mul_b = 32'(tap_q);
				end else begin
					mul_a = 32'(tap_q);
					mul_b = $signed({15'd0, wet_m});
				end
			end
			ST_FEED: begin
				if (peak_q < rect) begin
					mul_a = $signed({8'd0, rect - peak_q});
					mul_b = RISE_Q24;
				end else begin
					mul_a = $signed({8'd0, peak_q});
					mul_b = DECAY_Q24;
				end
			end
			ST_PEAK: begin
				mul_a = POLY_K3;
				mul_b = $signed({8'd0, peak_new});
			end
			ST_POLY2, ST_POLY1: begin
				mul_a = poly_g;
				mul_b = $signed({8'd0, peak_q});
			end
			ST_POLY0: begin
				mul_a = feed_q;
				mul_b = poly_g;
			end
			ST_WRITE: ram_we = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			h_q <= 2'd0;
			prev_in_q <= 24'sd0;
			prev_ap_q <= 24'sd0;
			peak_q <= PEAK_RESET;
			wp_q <= '0;
			fill_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MIX1 && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_PHASE: h_q <= 2'd0;
				ST_COS_DIV: begin
					if (h_q == 2'd0) begin
						h_q <= 2'd1;
					end
				end
				ST_COS_ACC: begin
					if (h_q != 2'd3) begin
						h_q <= h_q + 2'd1;
					end
				end
				ST_AP_SUM: begin
					prev_in_q <= fold_q;
					prev_ap_q <= ap_sat;
				end
				ST_PEAK: peak_q <= peak_new;
				ST_WRITE: begin
					wp_q <= (wp_q == '0) ? AW'(DELAY_DEPTH - 1) : wp_q - AW'(1);
					if (fill_q != (AW + 1)'(DELAY_DEPTH)) begin
						fill_q <= fill_q + (AW + 1)'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: x_q <= sample_in;
			ST_PHASE: begin
				u_q <= p_q[40:23] + fold_offset_q[17:0];
				sum_q <= 27'sd0;
			end
			ST_COS_ADDR: begin
				neg_q <= (ph[17:16] == 2'd1) || (ph[17:16] == 2'd2);
				fr_q <= pos[15:0];
			end
			ST_COS_INTERP: v0_q <= rom0;
			ST_COS_DIV: begin
				csgn_q <= cos_v[25];
				if (h_q == 2'd0) begin
					sum_q <= 27'(cos_v);
				end
			end
			ST_COS_ACC: begin
				if (h_q == 2'd2) begin
					sum_q <= sum_q + dterm;
				end else begin
					sum_q <= sum_q - dterm;
				end
			end
			ST_AP: fold_q <= fold_w[23:0];
			ST_AP_SUM: begin
				lp_q <= lp_sum[24:1];
				valid0_q <= is_written(rp, fill_q);
			end
			ST_RD0: begin
				t0_q <= valid0_q ? $signed(ram_rdata) : 24'sd0;
				valid1_q <= is_written(rp1, fill_q);
			end
			ST_TAP: tap_q <= tap_v;
			ST_MIX0: acc_q <= p_q;
			ST_MIX1: begin
				if (out_free) begin
					sample_out_q <= mix_o;
				end
			end
			ST_FEED: begin
				feed_q <= feed_v;
				rise_q <= peak_q < rect;
			end
			ST_PEAK: begin
				if (peak_new > PEAK_TWO) begin
					feed_q <= feed_q >>> 1;
				end
			end
			ST_SCALE: feed_q <= p_q[55:24];
			default: begin
			end
		endcase
	end

endmodule

@@ hw/rtl/wlfd_checker.sv @@
`include "wavefold_lowpass_feedback_delay_unit_macros.svh"

module wlfd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [23:0] sample_out
);

	`WLFD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sample_out))
	`WLFD_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)
	`WLFD_ASSERT_SAME(a_result_while_busy, $rose(out_valid), !in_ready)
	`WLFD_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready, !$rose(out_valid))

endmodule

bind wavefold_lowpass_feedback_delay_unit wlfd_checker u_wlfd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.sample_out (sample_out)
);

@@ dv/tb_wavefold_lowpass_feedback_delay_unit.sv @@
`timescale 1ns / 100ps

module tb_wavefold_lowpass_feedback_delay_unit;
	import wlfd_pkg::*;

	localparam int DEPTH = 65536;
	localparam int TAB_N = 1024;
	localparam int IDLE_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 40;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [4:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_ready;
	logic signed [23:0] sample_in;
	logic               out_valid;
	logic               out_ready;
	logic signed [23:0] sample_out;

	wavefold_lowpass_feedback_delay_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample_in(sample_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample_out(sample_out)
	);

	logic [23:0] m_gain;
	logic [23:0] m_offset;
	logic [23:0] m_coeff;
	logic [23:0] m_delay;
	logic [15:0] m_fb;
	logic [16:0] m_wet;
	longint      prev_fold;
	longint      prev_allpass;
	longint      peak;
	longint      echo_line [DEPTH];
	int          wr_pos;
	longint      cos_tab [TAB_N + 1];

	logic signed [23:0] expected_samples [$];
	int  mismatches;
	int  idle_cycles;
	bit  quiet;
	int  stall_left;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic void fill_cos_table();
		longint unsigned a;
		longint unsigned a2;
		longint unsigned term;
		longint          acc;
		for (int i = 0; i <= TAB_N; i++) begin
			a = (64'd1686629713 * longint'(i)) / TAB_N;
			a2 = (a * a) >> 30;
			term = 64'd1 << 30;
			acc = longint'(term);
			for (int n = 1; n <= 8; n++) begin
				term = ((term * a2) >> 30) / longint'((2 * n - 1) * (2 * n));
				if (n % 2 == 1) begin
					acc = acc - longint'(term);
				end else begin
					acc = acc + longint'(term);
				end
			end
			cos_tab[i] = (acc > 0) ? ((acc + 64) >>> 7) : 0;
		end
	endfunction

	function automatic longint quarter_cosine(longint r);
		longint pos;
		longint idx;
		longint fr;
		pos = r * TAB_N;
		idx = pos >>> 16;
		fr = pos & 64'sd65535;
		if (idx >= TAB_N) begin
			return cos_tab[TAB_N];
		end
		return cos_tab[idx] + (((cos_tab[idx + 1] - cos_tab[idx]) * fr) >>> 16);
	endfunction

	function automatic longint phase_cosine(longint u);
		longint p;
		longint r;
		p = u & 64'sd262143;
		r = p & 64'sd65535;
		case (p >>> 16)
			0: return quarter_cosine(r);
			1: return -quarter_cosine(64'sd65536 - r);
			2: return -quarter_cosine(r);
			default: return quarter_cosine(64'sd65536 - r);
		endcase
	endfunction

	function automatic longint clip24(longint v);
		if (v > 64'sd8388607) begin
			return 64'sd8388607;
		end
		if (v < -64'sd8388608) begin
			return -64'sd8388608;
		end
		return v;
	endfunction

	function automatic logic signed [23:0] process_sample(logic signed [23:0] s);
		longint x, u, sm, fold, c, ap, lp, d, t0, t1, tap, m, o, feed, mag, rect, g;
		int rp, rp1;
		x = longint'(s);
		u = ((longint'(m_gain) * x) >>> 23) + longint'($signed(m_offset));
		sm = phase_cosine(u) - phase_cosine(3 * u) / 9 + phase_cosine(5 * u) / 25
			- phase_cosine(7 * u) / 49;
		fold = sm >>> 1;
		c = longint'($signed(m_coeff));
		ap = clip24((c * (fold - prev_allpass) + prev_fold * 64'sd8388608) >>> 23);
		prev_fold = fold;
		prev_allpass = ap;
		lp = (fold + ap) >>> 1;
		d = longint'(m_delay);
		if (d < 256) d = 256;
		if (d > (DEPTH - 1) * 256) d = (DEPTH - 1) * 256;
		rp = wr_pos + int'(d >>> 8);
		if (rp >= DEPTH) rp -= DEPTH;
		rp1 = rp + 1;
		if (rp1 >= DEPTH) rp1 -= DEPTH;
		t0 = echo_line[rp];
		t1 = echo_line[rp1];
		tap = t0 + (((t1 - t0) * (d & 64'sd255)) >>> 8);
		m = (m_wet > 17'd65536) ? 64'sd65536 : longint'(m_wet);
		o = clip24((lp * (64'sd65536 - m) + tap * m) >>> 16);
		feed = lp + ((longint'(m_fb) * tap) >>> 15);
		mag = (feed < 0) ? -feed : feed;
		rect = mag >>> 1;
		if (rect > 64'sd16777215) rect = 64'sd16777215;
		if (peak < rect) begin
			peak = peak + (((rect - peak) * 64'sd5033165) >>> 24);
		end else begin
			peak = (peak * 64'sd16760439) >>> 24;
		end
		if (peak > 64'sd16777215) peak = 64'sd16777215;
		if (peak > 64'sd4194304) feed = feed >>> 1;
		if (peak > 64'sd1048576) begin
			g = 64'sd14904709 - ((64'sd3028019 * peak) >>> 21);
			g = -64'sd26939595 + ((g * peak) >>> 21);
			g = 64'sd26869366 + ((g * peak) >>> 21);
			feed = (feed * g) >>> 24;
		end
		if (feed > 64'sd4194304) feed = 64'sd4194304;
		if (feed < -64'sd4194304) feed = -64'sd4194304;
		echo_line[wr_pos] = feed;
		wr_pos = (wr_pos == 0) ? DEPTH - 1 : wr_pos - 1;
		return o[23:0];
	endfunction

	function automatic int pick_gap();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 99) < 25) begin
			stall_left <= pick_gap();
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (expected_samples.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected sample_out %0d", sample_out);
			end else begin
				if (sample_out !== expected_samples[0]) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("sample_out expected %0d actual %0d",
							expected_samples[0], sample_out);
					end
				end
				void'(expected_samples.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("wavefold_lowpass_feedback_delay_unit: mismatch");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_sample(logic signed [23:0] s);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		sample_in <= s;
		forever begin
			@(posedge clk);
			if (in_ready) break;
		end
		expected_samples.push_back(process_sample(s));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (expected_samples.size() == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		wait_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		forever begin
			@(posedge clk);
			if (pready) break;
		end
		case (idx)
			REG_FOLD_GAIN: m_gain = value[23:0];
			REG_FOLD_OFFSET: m_offset = value[23:0];
			REG_LOWPASS_COEFF: m_coeff = value[23:0];
			REG_DELAY_LENGTH: m_delay = value[23:0];
			REG_FEEDBACK_GAIN: m_fb = value[15:0];
			REG_WET_MIX: m_wet = value[16:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_all(logic [31:0] g, logic [31:0] o, logic [31:0] c,
			logic [31:0] d, logic [31:0] f, logic [31:0] w);
		write_reg(REG_FOLD_GAIN, g);
		write_reg(REG_FOLD_OFFSET, o);
		write_reg(REG_LOWPASS_COEFF, c);
		write_reg(REG_DELAY_LENGTH, d);
		write_reg(REG_FEEDBACK_GAIN, f);
		write_reg(REG_WET_MIX, w);
	endtask

	function automatic logic signed [23:0] rand_sample();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return 24'($urandom);
		if (r < 85) return 24'($signed($urandom_range(0, 8191)) - 4096);
		if (r < 92) return 24'sd8388607;
		return -24'sd8388608;
	endfunction

	task automatic test_reset_defaults();
		send_sample(24'sd0);
		send_sample(24'sd8388607);
		send_sample(-24'sd8388608);
		send_sample(24'sd1);
		send_sample(-24'sd1);
	endtask

	task automatic test_extreme_settings();
		set_all(32'hFFFFFF, 32'h7FFFFF, 32'h7FFFFF, 32'd0, 32'hFFFF, 32'h1FFFF);
		send_sample(24'sd8388607);
		send_sample(-24'sd8388608);
		send_sample(24'sd4194304);
		send_sample(24'sd0);
		set_all(32'd0, 32'h800000, 32'h800000, 32'hFFFFFF, 32'd0, 32'd0);
		send_sample(24'sd8388607);
		send_sample(-24'sd8388608);
		send_sample(24'sd12345);
		write_reg(3'd6, 32'h123456);
		write_reg(3'd7, 32'hFFFFFFFF);
		set_all(32'h7FFFFF, 32'h400000, 32'h7FFFFF, 32'd256, 32'd39322, 32'd65536);
		for (int i = 0; i < 8; i++) begin
			send_sample((i % 2) ? -24'sd8388608 : 24'sd8388607);
		end
	endtask

	task automatic test_random_phase(int count);
		set_all($urandom_range(0, 99) < 20 ? 32'($urandom) : $urandom_range(0, 2000000),
			32'($urandom),
			32'($urandom),
			$urandom_range(0, 99) < 70 ? $urandom_range(0, 8000) : 32'($urandom),
			$urandom_range(0, 99) < 15 ? 32'($urandom) : $urandom_range(0, 39322),
			$urandom_range(0, 99) < 15 ? 32'($urandom) : $urandom_range(0, 65536));
		for (int i = 0; i < count; i++) begin
			send_sample(rand_sample());
		end
	endtask

	task automatic test_pause_until_empty();
		for (int i = 0; i < 10; i++) begin
			send_sample(rand_sample());
		end
		wait_drained();
		for (int i = 0; i < 10; i++) begin
			send_sample(rand_sample());
		end
	endtask

	task automatic test_no_idling();
		quiet = 1'b1;
		test_random_phase(100);
		quiet = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		sample_in = '0;
		out_ready = 1'b0;
		mismatches = 0;
		idle_cycles = 0;
		quiet = 1'b0;
		stall_left = 0;
		m_gain = FOLD_GAIN_RST;
		m_offset = FOLD_OFFSET_RST;
		m_coeff = LP_COEFF_RST;
		m_delay = DELAY_LEN_RST;
		m_fb = FB_GAIN_RST;
		m_wet = WET_MIX_RST;
		prev_fold = 0;
		prev_allpass = 0;
		peak = longint'(PEAK_RESET);
		wr_pos = 0;
		for (int i = 0; i < DEPTH; i++) echo_line[i] = 0;
		fill_cos_table();
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_extreme_settings();
		test_pause_until_empty();
		test_no_idling();
		for (int k = 0; k < 5; k++) begin
			test_random_phase(180);
		end
		wait_drained();
		if (mismatches == 0) begin
			$display("wavefold_lowpass_feedback_delay_unit: match");
		end else begin
			$display("wavefold_lowpass_feedback_delay_unit: mismatch");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/wlfd_pkg.sv
hw/rtl/wlfd_ram.sv
hw/rtl/wlfd_cos_rom.sv
hw/rtl/wlfd_mul.sv
hw/rtl/wavefold_lowpass_feedback_delay_unit.sv
hw/rtl/wlfd_checker.sv
dv/tb_wavefold_lowpass_feedback_delay_unit.sv
